### rtl/core/source_text_tokenizer_defines.svh
// ---------------------------------------------------------------------------
// source_text_tokenizer_defines.svh
// Assertion macros used by the tokenizer checker.
// ---------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define STT_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent
`define STT_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define STT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/stt_pkg.sv
// ---------------------------------------------------------------------------
// stt_pkg
// Types, token kinds, character codes and classifiers for the tokenizer.
// ---------------------------------------------------------------------------
package stt_pkg;

  // Port field widths
  localparam int CH_W     = 8;
  localparam int KIND_W   = 5;
  localparam int LINE_W   = 16;
  localparam int COL_W    = 16;
  localparam int OFF_W    = 24;
  localparam int LEN_W    = 16;
  localparam int HEAD_W   = 24;

  // Default counter widths
  localparam int POS_BITS_DEF   = 24;
  localparam int COUNT_BITS_DEF = 16;

  // Results per input byte and result queue depth (power of two)
  localparam int MAX_RESULTS    = 3;
  localparam int BURST_CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int RES_FIFO_DEPTH = 4;

  // Token kinds
  localparam logic [KIND_W-1:0] K_EOF    = 5'd0;
  localparam logic [KIND_W-1:0] K_ERROR  = 5'd1;
  localparam logic [KIND_W-1:0] K_INT    = 5'd2;
  localparam logic [KIND_W-1:0] K_FLOAT  = 5'd3;
  localparam logic [KIND_W-1:0] K_IDENT  = 5'd4;
  localparam logic [KIND_W-1:0] K_STRING = 5'd5;
  localparam logic [KIND_W-1:0] K_FN     = 5'd6;
  localparam logic [KIND_W-1:0] K_VAR    = 5'd7;
  localparam logic [KIND_W-1:0] K_OBJ    = 5'd8;
  localparam logic [KIND_W-1:0] K_LPAREN = 5'd9;
  localparam logic [KIND_W-1:0] K_RPAREN = 5'd10;
  localparam logic [KIND_W-1:0] K_LBRACE = 5'd11;
  localparam logic [KIND_W-1:0] K_RBRACE = 5'd12;
  localparam logic [KIND_W-1:0] K_LBRACK = 5'd13;
  localparam logic [KIND_W-1:0] K_RBRACK = 5'd14;
  localparam logic [KIND_W-1:0] K_SEMI   = 5'd15;
  localparam logic [KIND_W-1:0] K_COLON  = 5'd16;
  localparam logic [KIND_W-1:0] K_PERIOD = 5'd17;
  localparam logic [KIND_W-1:0] K_COMMA  = 5'd18;
  localparam logic [KIND_W-1:0] K_PLUS   = 5'd19;
  localparam logic [KIND_W-1:0] K_MINUS  = 5'd20;
  localparam logic [KIND_W-1:0] K_STAR   = 5'd21;
  localparam logic [KIND_W-1:0] K_DIV    = 5'd22;
  localparam logic [KIND_W-1:0] K_ASSIGN = 5'd23;
  localparam logic [KIND_W-1:0] K_EQ     = 5'd24;
  localparam logic [KIND_W-1:0] K_NOT    = 5'd25;
  localparam logic [KIND_W-1:0] K_NE     = 5'd26;
  localparam logic [KIND_W-1:0] K_GT     = 5'd27;
  localparam logic [KIND_W-1:0] K_GE     = 5'd28;
  localparam logic [KIND_W-1:0] K_LT     = 5'd29;
  localparam logic [KIND_W-1:0] K_LE     = 5'd30;
  localparam logic [KIND_W-1:0] K_LAST   = K_LE;

  // Character codes
  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_0      = 8'h30;
  localparam logic [CH_W-1:0] CH_9      = 8'h39;
  localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CH_W-1:0] CH_EQUAL  = 8'h3D;
  localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CH_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [CH_W-1:0] CH_UC_Z   = 8'h5A;
  localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CH_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CH_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [CH_W-1:0] CH_LC_Z   = 8'h7A;
  localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;

  // Keyword heads: up to three leading bytes of an identifier
  localparam logic [HEAD_W-1:0] KW_FN  = 24'h00666E;
  localparam logic [HEAD_W-1:0] KW_VAR = 24'h766172;
  localparam logic [HEAD_W-1:0] KW_OBJ = 24'h6F626A;

  // Lexer mode, one-hot
  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_INT     = 8'b0000_0010,
    M_INT_DOT = 8'b0000_0100,
    M_FLOAT   = 8'b0000_1000,
    M_IDENT   = 8'b0001_0000,
    M_STRING  = 8'b0010_0000,
    M_COMMENT = 8'b0100_0000,
    M_OP      = 8'b1000_0000
  } mode_t;

  // Operator waiting for its lookahead byte
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_ASSIGN = 3'd1,
    OP_BANG   = 3'd2,
    OP_GT     = 3'd3,
    OP_LT     = 3'd4,
    OP_SLASH  = 3'd5
  } op_t;

  // One result beat
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic              last;
  } tok_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [BURST_CNT_W-1:0]      count;
    tok_t [MAX_RESULTS-1:0]      tok;
  } burst_t;

  function automatic logic is_numeral(input logic [CH_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_skip(input logic [CH_W-1:0] c);
    return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB) ||
           (c == CH_LF);
  endfunction

  function automatic logic is_op_start(input logic [CH_W-1:0] c);
    return (c == CH_EQUAL) || (c == CH_BANG) || (c == CH_GT) || (c == CH_LT) ||
           (c == CH_SLASH);
  endfunction

  function automatic op_t op_code(input logic [CH_W-1:0] c);
    op_t o;
    case (c)
      CH_EQUAL: o = OP_ASSIGN;
      CH_BANG:  o = OP_BANG;
      CH_GT:    o = OP_GT;
      CH_LT:    o = OP_LT;
      default:  o = OP_SLASH;
    endcase
    return o;
  endfunction

  // Kind of a comparison operator, with or without a trailing '='
  function automatic logic [KIND_W-1:0] op_kind(input op_t o, input logic with_eq);
    logic [KIND_W-1:0] k;
    case (o)
      OP_ASSIGN: k = with_eq ? K_EQ : K_ASSIGN;
      OP_BANG:   k = with_eq ? K_NE : K_NOT;
      OP_GT:     k = with_eq ? K_GE : K_GT;
      OP_LT:     k = with_eq ? K_LE : K_LT;
      default:   k = K_DIV;
    endcase
    return k;
  endfunction

  // Single-byte punctuation; anything else is an error token
  function automatic logic [KIND_W-1:0] single_kind(input logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LBRACK: k = K_LBRACK;
      CH_RBRACK: k = K_RBRACK;
      CH_SEMI:   k = K_SEMI;
      CH_COLON:  k = K_COLON;
      CH_DOT:    k = K_PERIOD;
      CH_COMMA:  k = K_COMMA;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/stt_lexer.sv
// ---------------------------------------------------------------------------
// stt_lexer
// Lexer state and the single-pass step that turns one byte into up to three
// token beats.
// ---------------------------------------------------------------------------
module stt_lexer #(
  parameter int POS_BITS   = stt_pkg::POS_BITS_DEF,
  parameter int COUNT_BITS = stt_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [stt_pkg::CH_W-1:0] ch,
  output stt_pkg::burst_t        burst
);
  import stt_pkg::*;

  localparam int SUM_W = ((POS_BITS > COUNT_BITS) ? POS_BITS : COUNT_BITS) + 1;
  localparam logic [POS_BITS-1:0]   POS_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // State
  mode_t                 mode, mode_next;
  op_t                   pend, pend_next;
  logic [POS_BITS-1:0]   st_off, st_off_next;
  logic [COUNT_BITS-1:0] st_line, st_line_next;
  logic [COUNT_BITS-1:0] st_col, st_col_next;
  logic [COUNT_BITS-1:0] run_len, run_len_next;
  logic [HEAD_W-1:0]     head, head_next;
  logic [POS_BITS-1:0]   cur_off, cur_off_next;
  logic [COUNT_BITS-1:0] cur_line, cur_line_next;
  logic [COUNT_BITS-1:0] cur_col, cur_col_next;

  // Step terms
  logic                   consumed;
  logic                   start_run;
  logic [1:0]             close_n;
  tok_t                   close_tok0, close_tok1;
  logic                   start_v;
  tok_t                   start_tok;
  logic                   eof_v;
  tok_t                   eof_tok;
  logic [BURST_CNT_W-1:0] slot;
  logic [KIND_W-1:0]      id_kind;

  function automatic logic [COUNT_BITS-1:0] cnt_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = (COUNT_BITS+1)'(a) + (COUNT_BITS+1)'(b);
    return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [POS_BITS-1:0] pos_add(input logic [POS_BITS-1:0]   a,
                                                  input logic [COUNT_BITS-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'(POS_MAX)) ? POS_MAX : POS_BITS'(s);
  endfunction

  function automatic tok_t mk_tok(input logic [KIND_W-1:0]     k,
                                  input logic [POS_BITS-1:0]   off,
                                  input logic [COUNT_BITS-1:0] ln,
                                  input logic [COUNT_BITS-1:0] col,
                                  input logic [COUNT_BITS-1:0] len);
    tok_t t;
    t.kind   = k;
    t.line   = LINE_W'(ln);
    t.column = COL_W'(col);
    t.offset = OFF_W'(off);
    t.length = LEN_W'(len);
    t.last   = 1'b0;
    return t;
  endfunction

  // Classify a finished identifier against the keywords
  always_comb begin
    if (run_len == COUNT_BITS'(2) && head == KW_FN) begin
      id_kind = K_FN;
    end else if (run_len == COUNT_BITS'(3) && head == KW_VAR) begin
      id_kind = K_VAR;
    end else if (run_len == COUNT_BITS'(3) && head == KW_OBJ) begin
      id_kind = K_OBJ;
    end else begin
      id_kind = K_IDENT;
    end
  end

  // Step: close or extend the open token, start the next, handle end of text
  always_comb begin
    mode_next     = mode;
    pend_next     = pend;
    st_off_next   = st_off;
    st_line_next  = st_line;
    st_col_next   = st_col;
    run_len_next  = run_len;
    head_next     = head;
    cur_off_next  = cur_off;
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    consumed      = 1'b0;
    start_run     = 1'b0;
    close_n       = 2'd0;
    close_tok0    = '0;
    close_tok1    = '0;
    start_v       = 1'b0;
    start_tok     = '0;
    eof_v         = 1'b0;
    eof_tok       = '0;

    // Extend or close the open token
    case (mode)
      M_INT: begin
        if (is_numeral(ch)) begin
          run_len_next = cnt_add(run_len, COUNT_BITS'(1));
          consumed     = 1'b1;
        end else if (ch == CH_DOT) begin
          mode_next = M_INT_DOT;
          consumed  = 1'b1;
        end else begin
          close_n    = 2'd1;
          close_tok0 = mk_tok(K_INT, st_off, st_line, st_col, run_len);
        end
      end
      M_INT_DOT: begin
        if (is_numeral(ch)) begin
          run_len_next = cnt_add(run_len, COUNT_BITS'(2));
          mode_next    = M_FLOAT;
          consumed     = 1'b1;
        end else begin
          // digits then a lone period: integer, then the period
          close_n    = 2'd2;
          close_tok0 = mk_tok(K_INT, st_off, st_line, st_col, run_len);
          close_tok1 = mk_tok(K_PERIOD, pos_add(st_off, run_len), st_line,
                              cnt_add(st_col, run_len), COUNT_BITS'(1));
        end
      end
      M_FLOAT: begin
        if (is_numeral(ch)) begin
          run_len_next = cnt_add(run_len, COUNT_BITS'(1));
          consumed     = 1'b1;
        end else begin
          close_n    = 2'd1;
          close_tok0 = mk_tok(K_FLOAT, st_off, st_line, st_col, run_len);
        end
      end
      M_IDENT: begin
        if (is_letter(ch)) begin
          if (run_len < COUNT_BITS'(3)) begin
            head_next = {head[HEAD_W-CH_W-1:0], ch};
          end
          run_len_next = cnt_add(run_len, COUNT_BITS'(1));
          consumed     = 1'b1;
        end else begin
          close_n    = 2'd1;
          close_tok0 = mk_tok(id_kind, st_off, st_line, st_col, run_len);
        end
      end
      M_STRING: begin
        if (ch == CH_NUL) begin
          // unterminated string
          close_n    = 2'd1;
          close_tok0 = mk_tok(K_ERROR, st_off, st_line, st_col, run_len);
        end else begin
          run_len_next = cnt_add(run_len, COUNT_BITS'(1));
          consumed     = 1'b1;
          if (ch == CH_DQUOTE) begin
            close_n    = 2'd1;
            close_tok0 = mk_tok(K_STRING, st_off, st_line, st_col, run_len_next);
            mode_next  = M_IDLE;
          end
        end
      end
      M_COMMENT: begin
        consumed = (ch != CH_LF) && (ch != CH_NUL);
      end
      M_OP: begin
        if (pend == OP_SLASH) begin
          if (ch == CH_SLASH) begin
            mode_next = M_COMMENT;
            consumed  = 1'b1;
          end else begin
            close_n    = 2'd1;
            close_tok0 = mk_tok(K_DIV, st_off, st_line, st_col, run_len);
          end
        end else if (ch == CH_EQUAL) begin
          run_len_next = COUNT_BITS'(2);
          close_n      = 2'd1;
          close_tok0   = mk_tok(op_kind(pend, 1'b1), st_off, st_line, st_col,
                                COUNT_BITS'(2));
          mode_next    = M_IDLE;
          consumed     = 1'b1;
        end else begin
          close_n    = 2'd1;
          close_tok0 = mk_tok(op_kind(pend, 1'b0), st_off, st_line, st_col, run_len);
        end
      end
      default: begin
      end
    endcase

    // Start the next token from this byte
    if (!consumed) begin
      mode_next = M_IDLE;
      if (is_numeral(ch)) begin
        mode_next = M_INT;
        start_run = 1'b1;
      end else if (is_letter(ch)) begin
        mode_next = M_IDENT;
        start_run = 1'b1;
        head_next = HEAD_W'(ch);
      end else if (ch == CH_DQUOTE) begin
        mode_next = M_STRING;
        start_run = 1'b1;
      end else if (is_op_start(ch)) begin
        mode_next = M_OP;
        start_run = 1'b1;
        pend_next = op_code(ch);
      end else if (!is_skip(ch)) begin
        start_v   = 1'b1;
        start_tok = mk_tok(single_kind(ch), cur_off, cur_line, cur_col, COUNT_BITS'(1));
      end
    end
    if (start_run) begin
      st_off_next  = cur_off;
      st_line_next = cur_line;
      st_col_next  = cur_col;
      run_len_next = COUNT_BITS'(1);
    end

    // End of text: emit EOF and return to reset; otherwise advance position
    if (ch == CH_NUL) begin
      eof_v         = 1'b1;
      eof_tok       = mk_tok(K_EOF, cur_off, cur_line, cur_col, '0);
      mode_next     = M_IDLE;
      pend_next     = OP_NONE;
      st_off_next   = '0;
      st_line_next  = COUNT_BITS'(1);
      st_col_next   = COUNT_BITS'(1);
      run_len_next  = '0;
      head_next     = '0;
      cur_off_next  = '0;
      cur_line_next = COUNT_BITS'(1);
      cur_col_next  = COUNT_BITS'(1);
    end else begin
      cur_off_next = pos_add(cur_off, COUNT_BITS'(1));
      if (ch == CH_LF) begin
        cur_line_next = cnt_add(cur_line, COUNT_BITS'(1));
        cur_col_next  = COUNT_BITS'(1);
      end else begin
        cur_col_next = cnt_add(cur_col, COUNT_BITS'(1));
      end
    end

    // Drop a pending operator once its mode is left
    if (mode_next != M_OP && mode_next != M_COMMENT) begin
      pend_next = OP_NONE;
    end
  end

  // Pack the beats in order and mark the last one
  always_comb begin
    burst = '0;
    if (close_n != 2'd0) begin
      burst.tok[0] = close_tok0;
    end
    if (close_n == 2'd2) begin
      burst.tok[1] = close_tok1;
    end
    slot = BURST_CNT_W'(close_n);
    if (start_v && slot < BURST_CNT_W'(MAX_RESULTS)) begin
      burst.tok[slot] = start_tok;
      slot            = slot + BURST_CNT_W'(1);
    end
    if (eof_v && slot < BURST_CNT_W'(MAX_RESULTS)) begin
      burst.tok[slot] = eof_tok;
      slot            = slot + BURST_CNT_W'(1);
    end
    burst.count = slot;
    if (slot != '0) begin
      burst.tok[slot - BURST_CNT_W'(1)].last = 1'b1;
    end
  end

  // Advance state on each stepped byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      pend     <= OP_NONE;
      st_off   <= '0;
      st_line  <= COUNT_BITS'(1);
      st_col   <= COUNT_BITS'(1);
      run_len  <= '0;
      head     <= '0;
      cur_off  <= '0;
      cur_line <= COUNT_BITS'(1);
      cur_col  <= COUNT_BITS'(1);
    end else if (step) begin
      mode     <= mode_next;
      pend     <= pend_next;
      st_off   <= st_off_next;
      st_line  <= st_line_next;
      st_col   <= st_col_next;
      run_len  <= run_len_next;
      head     <= head_next;
      cur_off  <= cur_off_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
    end
  end

endmodule

### rtl/core/stt_result_fifo.sv
// ---------------------------------------------------------------------------
// stt_result_fifo
// Small result queue: takes up to three beats per cycle, hands out one.
// ---------------------------------------------------------------------------
module stt_result_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  stt_pkg::burst_t burst,
  input  logic            pop,
  output stt_pkg::tok_t   head,
  output logic            valid,
  output logic            room
);
  import stt_pkg::*;

  localparam int DEPTH = RES_FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] push_n;

  assign push_n = push ? CNT_W'(burst.count) : '0;
  assign valid  = (count != '0);
  assign head   = mem[rd_ptr];
  // room for a full burst, ignoring this cycle's pop
  assign room   = (count <= CNT_W'(DEPTH - MAX_RESULTS));

  // Write the burst's beats at consecutive slots; pointers wrap on a power of two
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RESULTS; j++) begin
      if (push && (BURST_CNT_W'(j) < burst.count)) begin
        mem[wr_ptr + PTR_W'(j)] <= burst.tok[j];
      end
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + push_n - CNT_W'(pop);
    end
  end

endmodule

### rtl/core/source_text_tokenizer.sv
// ---------------------------------------------------------------------------
// source_text_tokenizer: streaming lexer, one source byte per beat in
// Path: a byte is held in the input register, then stepped through the lexer into
// the result queue once the queue has room for a full burst.
// Throughput: one byte per cycle while the queue has room for a full burst.
// Reset: rst clears position, lexer mode and the result queue; a 0 byte resets too.
// ---------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int POS_BITS   = stt_pkg::POS_BITS_DEF,
  parameter int COUNT_BITS = stt_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [stt_pkg::CH_W-1:0]   ch,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [stt_pkg::KIND_W-1:0] kind,
  output logic [stt_pkg::LINE_W-1:0] tok_line,
  output logic [stt_pkg::COL_W-1:0]  tok_column,
  output logic [stt_pkg::OFF_W-1:0]  tok_offset,
  output logic [stt_pkg::LEN_W-1:0]  tok_length,
  output logic                       last
);
  import stt_pkg::*;

  logic            in_full;
  logic [CH_W-1:0] ch_q;
  logic            advance;
  logic            room;
  logic            pop;
  burst_t          burst;
  tok_t            head;

  // Step the lexer when a byte is held and the queue can take a full burst
  assign advance  = in_full && room;
  assign in_stall = in_full && !room;
  assign pop      = out_valid && !out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_q <= ch;
    end
  end

  stt_lexer #(
    .POS_BITS   (POS_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_lexer (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .ch    (ch_q),
    .burst (burst)
  );

  stt_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (advance),
    .burst (burst),
    .pop   (pop),
    .head  (head),
    .valid (out_valid),
    .room  (room)
  );

  // Result beat fields
  assign kind       = head.kind;
  assign tok_line   = head.line;
  assign tok_column = head.column;
  assign tok_offset = head.offset;
  assign tok_length = head.length;
  assign last       = head.last;

endmodule

### rtl/core/stt_checker.sv
// ---------------------------------------------------------------------------
// stt_checker
// Port-level checks on the tokenizer result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "source_text_tokenizer_defines.svh"

module stt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [stt_pkg::KIND_W-1:0] kind,
  input logic [stt_pkg::LINE_W-1:0] tok_line,
  input logic [stt_pkg::COL_W-1:0]  tok_column,
  input logic [stt_pkg::OFF_W-1:0]  tok_offset,
  input logic [stt_pkg::LEN_W-1:0]  tok_length,
  input logic                       last
);
  import stt_pkg::*;

  logic                    stalled;
  logic                    eof_beat;
  logic                    tok_beat;
  logic [$bits(tok_t)-1:0] beat;

  assign stalled  = out_valid && out_stall;
  assign eof_beat = out_valid && (kind == K_EOF);
  assign tok_beat = out_valid && (kind != K_EOF);
  assign beat     = {kind, tok_line, tok_column, tok_offset, tok_length, last};

  // A stalled result beat holds
  `STT_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(beat), "stalled beat changed")

  // EOF closes its byte's burst and has no length; every other token has a length
  `STT_ASSERT_SAME(a_eof_shape, eof_beat, last && tok_length == '0, "bad EOF beat")
  `STT_ASSERT_SAME(a_tok_len, tok_beat, tok_length != '0, "token with zero length")

  // Positions count from one and kinds stay in range
  `STT_ASSERT_SAME(a_pos_range, out_valid, tok_line != '0 && tok_column != '0, "position is zero")
  `STT_ASSERT_ALWAYS(a_kind_range, !out_valid || kind <= K_LAST, "kind out of range")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

### tb/sv/source_text_tokenizer_tb.sv
// ---------------------------------------------------------------------------
// source_text_tokenizer_tb
// Self-checking bench for the streaming tokenizer. A directed table hits the
// lookahead corner cases. Random texts built from token fragments follow,
// under several sender and receiver idling mixes. Every token beat is
// compared field by field with a pinned token or an in-bench lexer that tracks the same state.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module source_text_tokenizer_tb;
  import stt_pkg::*;

  localparam int unsigned POS_MAX = (32'd1 << POS_BITS_DEF) - 1;
  localparam int unsigned CNT_MAX = (32'd1 << COUNT_BITS_DEF) - 1;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int DRAIN_CYCLES     = 16;
  localparam int PHASE_BYTES      = 100;
  localparam int DIRECTED_ROWS    = 25;

  // One directed row: a source byte and, where pinned, the single token it gives
  typedef struct packed {
    logic [CH_W-1:0] text_byte;
    logic            pinned;
    tok_t            pinned_tok;
  } lex_row_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [CH_W-1:0]     ch         = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [LINE_W-1:0]   tok_line;
  logic [COL_W-1:0]    tok_column;
  logic [OFF_W-1:0]    tok_offset;
  logic [LEN_W-1:0]    tok_length;
  logic                last;

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int mismatch_count = 0;
  int tokens_checked = 0;
  int bytes_accepted = 0;
  int texts_done     = 0;
  int cycle_count    = 0;

  // Lexer state mirrored by the bench
  mode_t       lex_mode;
  op_t         pend_op;
  int unsigned start_off, start_ln, start_col, run_len, head_bytes;
  int unsigned at_off, at_line, at_col;

  tok_t burst_buf [MAX_RESULTS];
  int   burst_n;
  tok_t pending_tokens [$];

  // Directed text: error byte, digits-dot burst, slash, keyword, compare op,
  // float, comment, unterminated string, empty text and a second keyword
  lex_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'hFF,     1'b1, '{K_ERROR, 16'd1, 16'd1, 24'd0, 16'd1, 1'b1}},
    '{"7",       1'b0, '0},
    '{CH_DOT,    1'b0, '0},
    '{CH_RPAREN, 1'b0, '0},
    '{CH_SLASH,  1'b0, '0},
    '{"f",       1'b0, '0},
    '{"n",       1'b0, '0},
    '{CH_LT,     1'b0, '0},
    '{CH_EQUAL,  1'b0, '0},
    '{"3",       1'b0, '0},
    '{CH_DOT,    1'b0, '0},
    '{"5",       1'b0, '0},
    '{CH_LF,     1'b0, '0},
    '{CH_SLASH,  1'b0, '0},
    '{CH_SLASH,  1'b0, '0},
    '{"q",       1'b0, '0},
    '{CH_LF,     1'b0, '0},
    '{CH_DQUOTE, 1'b0, '0},
    '{"v",       1'b0, '0},
    '{CH_NUL,    1'b0, '0},
    '{CH_NUL,    1'b1, '{K_EOF, 16'd1, 16'd1, 24'd0, 16'd0, 1'b1}},
    '{"o",       1'b0, '0},
    '{"b",       1'b0, '0},
    '{"j",       1'b0, '0},
    '{CH_NUL,    1'b0, '0}
  };

  source_text_tokenizer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .tok_line   (tok_line),
    .tok_column (tok_column),
    .tok_offset (tok_offset),
    .tok_length (tok_length),
    .last       (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Lexer model
  // ---------------------------------------------------------------------
  function automatic int unsigned sat_sum(input int unsigned a, input int unsigned b,
                                          input int unsigned lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic logic digit_ch(input logic [CH_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic letter_ch(input logic [CH_W-1:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic blank_ch(input logic [CH_W-1:0] c);
    return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB) ||
           (c == CH_LF);
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LBRACK: k = K_LBRACK;
      CH_RBRACK: k = K_RBRACK;
      CH_SEMI:   k = K_SEMI;
      CH_COLON:  k = K_COLON;
      CH_DOT:    k = K_PERIOD;
      CH_COMMA:  k = K_COMMA;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] compare_kind(input op_t o, input logic with_eq);
    logic [KIND_W-1:0] k;
    case (o)
      OP_ASSIGN: k = with_eq ? K_EQ : K_ASSIGN;
      OP_BANG:   k = with_eq ? K_NE : K_NOT;
      OP_GT:     k = with_eq ? K_GE : K_GT;
      OP_LT:     k = with_eq ? K_LE : K_LT;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] word_kind();
    if (run_len == 2 && head_bytes == KW_FN) return K_FN;
    if (run_len == 3 && head_bytes == KW_VAR) return K_VAR;
    if (run_len == 3 && head_bytes == KW_OBJ) return K_OBJ;
    return K_IDENT;
  endfunction

  task automatic reset_lexer();
    lex_mode   = M_IDLE;
    pend_op    = OP_NONE;
    start_off  = 0;
    start_ln   = 1;
    start_col  = 1;
    run_len    = 0;
    head_bytes = 0;
    at_off     = 0;
    at_line    = 1;
    at_col     = 1;
  endtask

  task automatic add_token(input logic [KIND_W-1:0] k, input int unsigned off,
                           input int unsigned ln, input int unsigned col,
                           input int unsigned len);
    tok_t t;
    if (burst_n < MAX_RESULTS) begin
      t.kind   = k;
      t.line   = ln[LINE_W-1:0];
      t.column = col[COL_W-1:0];
      t.offset = off[OFF_W-1:0];
      t.length = len[LEN_W-1:0];
      t.last   = 1'b0;
      burst_buf[burst_n] = t;
      burst_n++;
    end
  endtask

  task automatic close_run(input logic [KIND_W-1:0] k);
    add_token(k, start_off, start_ln, start_col, run_len);
  endtask

  task automatic open_run(input mode_t m);
    lex_mode  = m;
    start_off = at_off;
    start_ln  = at_line;
    start_col = at_col;
    run_len   = 1;
  endtask

  // Start whatever token this byte begins, from the idle state
  task automatic start_fresh(input logic [CH_W-1:0] c);
    lex_mode = M_IDLE;
    if (blank_ch(c)) begin
    end else if (digit_ch(c)) begin
      open_run(M_INT);
    end else if (letter_ch(c)) begin
      open_run(M_IDENT);
      head_bytes = 32'(c);
    end else if (c == CH_DQUOTE) begin
      open_run(M_STRING);
    end else if (c == CH_EQUAL || c == CH_BANG || c == CH_GT || c == CH_LT ||
                 c == CH_SLASH) begin
      open_run(M_OP);
      case (c)
        CH_EQUAL: pend_op = OP_ASSIGN;
        CH_BANG:  pend_op = OP_BANG;
        CH_GT:    pend_op = OP_GT;
        CH_LT:    pend_op = OP_LT;
        default:  pend_op = OP_SLASH;
      endcase
    end else begin
      add_token(punct_kind(c), at_off, at_line, at_col, 1);
    end
  endtask

  // Work out the token beats that one source byte causes, into burst_buf
  task automatic tokenize_byte(input logic [CH_W-1:0] c);
    logic taken;
    taken   = 1'b0;
    burst_n = 0;
    case (lex_mode)
      M_INT: begin
        if (digit_ch(c)) begin
          run_len = sat_sum(run_len, 1, CNT_MAX);
          taken   = 1'b1;
        end else if (c == CH_DOT) begin
          lex_mode = M_INT_DOT;
          taken    = 1'b1;
        end else begin
          close_run(K_INT);
        end
      end
      M_INT_DOT: begin
        if (digit_ch(c)) begin
          run_len  = sat_sum(run_len, 2, CNT_MAX);
          lex_mode = M_FLOAT;
          taken    = 1'b1;
        end else begin
          // digits then a lone period: INT, then PERIOD right after it
          close_run(K_INT);
          add_token(K_PERIOD, sat_sum(start_off, run_len, POS_MAX), start_ln,
                    sat_sum(start_col, run_len, CNT_MAX), 1);
        end
      end
      M_FLOAT: begin
        if (digit_ch(c)) begin
          run_len = sat_sum(run_len, 1, CNT_MAX);
          taken   = 1'b1;
        end else begin
          close_run(K_FLOAT);
        end
      end
      M_IDENT: begin
        if (letter_ch(c)) begin
          if (run_len < 3) head_bytes = ((head_bytes << 8) | 32'(c)) & 32'h00FF_FFFF;
          run_len = sat_sum(run_len, 1, CNT_MAX);
          taken   = 1'b1;
        end else begin
          close_run(word_kind());
        end
      end
      M_STRING: begin
        if (c == CH_NUL) begin
          close_run(K_ERROR);
        end else begin
          run_len = sat_sum(run_len, 1, CNT_MAX);
          taken   = 1'b1;
          if (c == CH_DQUOTE) begin
            close_run(K_STRING);
            lex_mode = M_IDLE;
          end
        end
      end
      M_COMMENT: begin
        taken = (c != CH_LF) && (c != CH_NUL);
      end
      M_OP: begin
        if (pend_op == OP_SLASH) begin
          if (c == CH_SLASH) begin
            lex_mode = M_COMMENT;
            taken    = 1'b1;
          end else begin
            close_run(K_DIV);
          end
        end else if (c == CH_EQUAL) begin
          run_len = 2;
          close_run(compare_kind(pend_op, 1'b1));
          lex_mode = M_IDLE;
          taken    = 1'b1;
        end else begin
          close_run(compare_kind(pend_op, 1'b0));
        end
        if (lex_mode != M_COMMENT) pend_op = OP_NONE;
      end
      default: begin
      end
    endcase

    if (!taken) start_fresh(c);

    // End of text: EOF at the current position, then back to reset state
    if (c == CH_NUL) begin
      add_token(K_EOF, at_off, at_line, at_col, 0);
      reset_lexer();
    end else begin
      at_off = sat_sum(at_off, 1, POS_MAX);
      if (c == CH_LF) begin
        at_line = sat_sum(at_line, 1, CNT_MAX);
        at_col  = 1;
      end else begin
        at_col = sat_sum(at_col, 1, CNT_MAX);
      end
    end
    if (lex_mode != M_OP && lex_mode != M_COMMENT) pend_op = OP_NONE;
    if (burst_n > 0) burst_buf[burst_n-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [CH_W-1:0] c, input logic pinned,
                           input tok_t pinned_tok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_accepted++;
    if (c == CH_NUL) texts_done++;
    tokenize_byte(c);
    if (pinned) begin
      pending_tokens.push_back(pinned_tok);
    end else begin
      for (int i = 0; i < burst_n; i++) pending_tokens.push_back(burst_buf[i]);
    end
  endtask

  task automatic feed(input logic [CH_W-1:0] c);
    send_byte(c, 1'b0, '0);
  endtask

  function automatic logic [CH_W-1:0] rand_digit();
    return CH_0 + CH_W'($urandom_range(9));
  endfunction

  function automatic logic [CH_W-1:0] rand_letter();
    int unsigned idx;
    idx = $urandom_range(52);
    if (idx < 26) return CH_LC_A + CH_W'(idx);
    if (idx < 52) return CH_UC_A + CH_W'(idx - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [CH_W-1:0] rand_punct();
    logic [CH_W-1:0] c;
    case ($urandom_range(12))
      0:       c = CH_LPAREN;
      1:       c = CH_RPAREN;
      2:       c = CH_LBRACE;
      3:       c = CH_RBRACE;
      4:       c = CH_LBRACK;
      5:       c = CH_RBRACK;
      6:       c = CH_SEMI;
      7:       c = CH_COLON;
      8:       c = CH_DOT;
      9:       c = CH_COMMA;
      10:      c = CH_PLUS;
      11:      c = CH_MINUS;
      default: c = CH_STAR;
    endcase
    return c;
  endfunction

  function automatic logic [CH_W-1:0] rand_blank();
    logic [CH_W-1:0] c;
    case ($urandom_range(3))
      0:       c = CH_SPACE;
      1:       c = CH_TAB;
      2:       c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

  // Any byte but the end marker and the quote
  function automatic logic [CH_W-1:0] rand_inner();
    logic [CH_W-1:0] c;
    c = CH_W'($urandom_range(1, 255));
    return (c == CH_DQUOTE) ? CH_SPACE : c;
  endfunction

  // Send one random piece of source text; adjacent pieces exercise lookahead
  task automatic send_fragment();
    string           word;
    logic [CH_W-1:0] c;
    case ($urandom_range(19))
      0, 1: begin
        repeat ($urandom_range(1, 4)) feed(rand_digit());
      end
      2: begin
        repeat ($urandom_range(1, 3)) feed(rand_digit());
        feed(CH_DOT);
        repeat ($urandom_range(1, 3)) feed(rand_digit());
      end
      3: begin
        repeat ($urandom_range(1, 2)) feed(rand_digit());
        feed(CH_DOT);
      end
      4, 5: begin
        repeat ($urandom_range(1, 5)) feed(rand_letter());
      end
      6: begin
        case ($urandom_range(8))
          0:       word = "fn";
          1:       word = "var";
          2:       word = "obj";
          3:       word = "f";
          4:       word = "va";
          5:       word = "ob";
          6:       word = "fnn";
          7:       word = "vars";
          default: word = "objs";
        endcase
        for (int i = 0; i < word.len(); i++) feed(word[i]);
      end
      7: begin
        feed(CH_DQUOTE);
        repeat ($urandom_range(0, 5)) feed(rand_inner());
        feed(CH_DQUOTE);
      end
      8: begin
        case ($urandom_range(3))
          0:       c = CH_EQUAL;
          1:       c = CH_BANG;
          2:       c = CH_GT;
          default: c = CH_LT;
        endcase
        feed(c);
        if ($urandom_range(1)) feed(CH_EQUAL);
      end
      9, 10: begin
        feed(rand_punct());
      end
      11: begin
        feed(CH_SLASH);
        feed(CH_SLASH);
        repeat ($urandom_range(0, 4)) begin
          c = rand_inner();
          feed(c == CH_LF ? CH_SPACE : c);
        end
        feed(CH_LF);
      end
      12: begin
        feed(CH_SLASH);
      end
      13, 14: begin
        repeat ($urandom_range(1, 3)) feed(rand_blank());
      end
      15: begin
        feed(CH_W'($urandom_range(1, 255)));
      end
      16: begin
        // string left open at end of text
        feed(CH_DQUOTE);
        repeat ($urandom_range(0, 3)) feed(rand_inner());
        feed(CH_NUL);
      end
      17: begin
        feed(CH_NUL);
      end
      default: begin
        feed(CH_SPACE);
      end
    endcase
  endtask

  task automatic run_phase(input int idle, input int stall);
    int goal;
    goal          = bytes_accepted + PHASE_BYTES;
    send_idle_pct = idle;
    stall_pct     = stall;
    while (bytes_accepted < goal) send_fragment();
  endtask

  initial begin
    reset_lexer();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].text_byte, directed_rows[i].pinned,
                directed_rows[i].pinned_tok);
    end

    // Random texts under each idling mix
    run_phase(0, 0);
    run_phase(63, 0);
    run_phase(0, 63);
    run_phase(22, 22);

    // Close the last text
    send_idle_pct = 0;
    stall_pct     = 0;
    feed(CH_NUL);
    in_valid <= 1'b0;

    // Drain, then give stray beats a chance to show up
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Lexed %0d source bytes in %0d texts and compared %0d token beats,",
             bytes_accepted, texts_done, tokens_checked);
    $display("with idle and stall mixes, lookahead bursts and strings left open.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: token %0d %s expected %0d, got %0d", $time, tokens_checked, name,
               want, got);
      mismatch_count++;
    end
  endtask

  // Compare each accepted beat with the oldest expected token
  always @(posedge clk) begin : watch_tokens
    tok_t want;
    if (!rst && out_stall === 1'b0 && out_valid !== 1'b0) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token beat, expected none, got kind %0d line %0d col %0d",
                 $time, kind, tok_line, tok_column);
        mismatch_count++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("line", 32'(want.line), 32'(tok_line));
        check_field("column", 32'(want.column), 32'(tok_column));
        check_field("offset", 32'(want.offset), 32'(tok_offset));
        check_field("length", 32'(want.length), 32'(tok_length));
        check_field("last", 32'(want.last), 32'(last));
        tokens_checked++;
      end
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles with %0d tokens outstanding", $time,
               cycle_count, pending_tokens.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/stt_pkg.sv
rtl/core/stt_lexer.sv
rtl/core/stt_result_fifo.sv
rtl/core/source_text_tokenizer.sv
rtl/core/stt_checker.sv
tb/sv/source_text_tokenizer_tb.sv
